// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked concurrent assertions with an active-low reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/bsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bsc_pkg
// Types, constants and helpers shared by the bitmap set/clear/find blocks.
// ----------------------------------------------------------------------------
package bsc_pkg;

  localparam int IdxW     = 12;
  localparam int ByteIdxW = IdxW - 3;
  localparam int ApbAddrW = 3;
  localparam int ApbDataW = 32;

  // Word index of the limit register within the configuration space.
  localparam logic RegHighestIndex = 1'b0;
  localparam logic [IdxW-1:0] HighestIndexRst = 12'd4095;

  typedef enum logic [1:0] {
    CmdSet   = 2'd0,
    CmdClear = 2'd1,
    CmdTest  = 2'd2,
    CmdFind  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e            command;
    logic [IdxW-1:0] index;
  } req_t;

  typedef struct packed {
    logic            bit_is_set;
    logic            found;
    logic [IdxW-1:0] first_index;
  } rsp_t;

  // Position of the lowest set bit of a byte; seven when the byte is zero.
  function automatic logic [2:0] lowest_set_pos(logic [7:0] b);
    logic [2:0] pos;
    pos = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (b[i]) begin
        pos = 3'(i);
      end
    end
    return pos;
  endfunction

endpackage

// ===== hw/rtl/bsc_stream_if.sv =====
// ----------------------------------------------------------------------------
// bsc_stream_if
// Valid/ready channel carrying one payload word per transaction.
// ----------------------------------------------------------------------------
interface bsc_stream_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

// ===== hw/rtl/bsc_store.sv =====
// ----------------------------------------------------------------------------
// bsc_store
// Byte-wide synchronous RAM, one write and one read port, registered read.
// ----------------------------------------------------------------------------
module bsc_store #(
  parameter int Depth = 512,
  parameter int AddrW = 9
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [7:0]       wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem_q [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/bitmap_set_clear_find_first.sv =====
// ----------------------------------------------------------------------------
// bitmap_set_clear_find_first
// A bit map of NUM_BITS bits kept in a byte-wide RAM, bit i in bit (i mod 8)
// of byte i/8. Each transaction on cmd_i sets, clears or tests one bit, or
// finds the lowest set bit at or below the highest_index register, and
// yields one transaction on res_o. Set, clear and test read the byte; set
// and clear then modify it and write it back. Find reads one byte per cycle
// from byte 0 up to the first non-zero one or up to the byte holding the
// limit (at most 512 bytes with the default size). The single RAM read port
// sets this pace. After reset a clearing pass writes zero to every byte, one
// per cycle; cmd_i is not ready during that pass, while register writes are
// taken throughout. A finished result sits in an output register, so the
// next command is accepted while it waits to be taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_set_clear_find_first #(
  parameter int NUM_BITS = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  bsc_stream_if.sink                    cmd_i,
  bsc_stream_if.source                  res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bsc_pkg::ApbAddrW-1:0]  paddr,
  input  logic [bsc_pkg::ApbDataW-1:0]  pwdata,
  output logic [bsc_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready
);

  localparam int StoreBytes = (NUM_BITS + 7) / 8;
  localparam int AddrW      = (StoreBytes > 1) ? $clog2(StoreBytes) : 1;
  localparam int MaxBit     = NUM_BITS - 1;

  typedef enum logic [3:0] {
    StClear = 4'b0001,
    StIdle  = 4'b0010,
    StLook  = 4'b0100,
    StEmit  = 4'b1000
  } state_e;

  state_e                        state_q, state_d;
  logic [AddrW-1:0]              clr_q, clr_d;
  logic [bsc_pkg::ByteIdxW-1:0]  scan_q, scan_d;
  bsc_pkg::cmd_e                 cmd_q, cmd_d;
  logic [bsc_pkg::IdxW-1:0]      idx_q, idx_d;
  logic [bsc_pkg::IdxW-1:0]      hi_q;
  bsc_pkg::rsp_t                 res_q, res_d;
  bsc_pkg::rsp_t                 out_q, out_d;
  logic                          out_valid_q, out_valid_d;

  logic                          mem_we;
  logic [AddrW-1:0]              mem_waddr;
  logic [7:0]                    mem_wdata;
  logic                          mem_re;
  logic [AddrW-1:0]              mem_raddr;
  logic [7:0]                    mem_rdata;

  logic                          cmd_accept;
  logic                          out_free;
  logic                          in_map;
  logic [7:0]                    bit_mask;
  logic [bsc_pkg::IdxW-1:0]      limit;
  logic [bsc_pkg::ByteIdxW-1:0]  last_byte;
  logic [bsc_pkg::IdxW-1:0]      hit_pos;
  logic                          look_done;
  bsc_pkg::rsp_t                 res_now;
  logic                          cfg_write;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready
                     && (paddr[2] == bsc_pkg::RegHighestIndex);
  assign prdata    = (paddr[2] == bsc_pkg::RegHighestIndex) ?
                     bsc_pkg::ApbDataW'(hi_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hi_q <= bsc_pkg::HighestIndexRst;
    end else if (cfg_write) begin
      hi_q <= pwdata[bsc_pkg::IdxW-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Datapath helpers
  // --------------------------------------------------------------------------
  assign in_map    = 32'(idx_q) < 32'(NUM_BITS);
  assign bit_mask  = 8'b1 << idx_q[2:0];
  // The search never looks past the last bit of the map.
  assign limit     = (32'(hi_q) > 32'(MaxBit)) ? bsc_pkg::IdxW'(MaxBit) : hi_q;
  assign last_byte = limit[bsc_pkg::IdxW-1:3];
  assign hit_pos   = {scan_q, bsc_pkg::lowest_set_pos(mem_rdata)};
  assign look_done = (cmd_q != bsc_pkg::CmdFind) || (mem_rdata != 8'd0)
                     || (scan_q == last_byte);

  always_comb begin
    res_now = '0;
    unique case (cmd_q)
      bsc_pkg::CmdSet, bsc_pkg::CmdClear: begin
      end
      bsc_pkg::CmdTest: begin
        res_now.bit_is_set = in_map && mem_rdata[idx_q[2:0]];
      end
      bsc_pkg::CmdFind: begin
        // The first non-zero byte ends the search even when its lowest bit
        // lies above the limit.
        if (mem_rdata != 8'd0) begin
          res_now.found       = hit_pos <= hi_q;
          res_now.first_index = (hit_pos <= hi_q) ? hit_pos : '0;
        end
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign cmd_i.ready = (state_q == StIdle);
  assign cmd_accept  = cmd_i.valid && cmd_i.ready;
  assign out_free    = !out_valid_q || res_o.ready;

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    scan_d      = scan_q;
    cmd_d       = cmd_q;
    idx_d       = idx_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !res_o.ready;
    mem_we      = 1'b0;
    mem_waddr   = AddrW'(idx_q[bsc_pkg::IdxW-1:3]);
    mem_wdata   = 8'd0;
    mem_re      = 1'b0;
    mem_raddr   = '0;

    unique case (state_q)
      StClear: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        if (clr_q == AddrW'(StoreBytes - 1)) begin
          state_d = StIdle;
        end else begin
          clr_d = AddrW'(clr_q + 1'b1);
        end
      end
      StIdle: begin
        if (cmd_accept) begin
          cmd_d  = cmd_i.payload.command;
          idx_d  = cmd_i.payload.index;
          scan_d = '0;
          mem_re = 1'b1;
          if (cmd_i.payload.command != bsc_pkg::CmdFind) begin
            mem_raddr = AddrW'(cmd_i.payload.index[bsc_pkg::IdxW-1:3]);
          end
          state_d = StLook;
        end
      end
      StLook: begin
        if ((cmd_q == bsc_pkg::CmdSet || cmd_q == bsc_pkg::CmdClear) && in_map) begin
          mem_we    = 1'b1;
          mem_wdata = (cmd_q == bsc_pkg::CmdSet) ? (mem_rdata | bit_mask)
                                                 : (mem_rdata & ~bit_mask);
        end
        if (!look_done) begin
          scan_d    = bsc_pkg::ByteIdxW'(scan_q + 1'b1);
          mem_re    = 1'b1;
          mem_raddr = AddrW'(scan_q + 1'b1);
        end else if (out_free) begin
          out_d       = res_now;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end else begin
          res_d   = res_now;
          state_d = StEmit;
        end
      end
      StEmit: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_q <= scan_d;
    cmd_q  <= cmd_d;
    idx_q  <= idx_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  bsc_store #(
    .Depth (StoreBytes),
    .AddrW (AddrW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `ASSERT_IMPLIES(a_no_cmd_in_clear, clk_i, rst_ni, state_q == StClear, !cmd_i.ready)
  `ASSERT_IMPLIES(a_write_when_allowed, clk_i, rst_ni, mem_we,
                  state_q == StClear || state_q == StLook)
  `ASSERT_IMPLIES(a_scan_within_limit, clk_i, rst_ni,
                  state_q == StLook && cmd_q == bsc_pkg::CmdFind, scan_q <= last_byte)
  `ASSERT_NEXT(a_accept_starts_lookup, clk_i, rst_ni, cmd_accept, state_q == StLook)

endmodule
